// ===== rtl/cwt_pkg.sv =====
// Types, action codes and helper functions for the clique witness transition core.
// Used by rtl/clique_witness_transition_core.sv; depends on nothing else.
`default_nettype none

package cwt_pkg;

	localparam logic [1:0] ACT_INTRO_VERTEX = 2'd0;
	localparam logic [1:0] ACT_INTRO_EDGE   = 2'd1;
	localparam logic [1:0] ACT_FORGET       = 2'd2;
	localparam logic [1:0] ACT_JOIN         = 2'd3;

	localparam logic [2:0] CLIQUE_SIZE_RESET = 3'd3;
	localparam int         NUM_EDGES         = 10;

	// endpoints of edge bit b+1 of a witness
	localparam logic [2:0] END_LOW [NUM_EDGES] =
		'{3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4};
	localparam logic [2:0] END_HIGH [NUM_EDGES] =
		'{3'd2, 3'd3, 3'd4, 3'd5, 3'd3, 3'd4, 3'd5, 3'd4, 3'd5, 3'd5};

	typedef struct packed {
		logic [1:0]  action;
		logic [10:0] witness_a;
		logic [10:0] witness_b;
		logic [2:0]  vertex_a;
		logic [2:0]  vertex_b;
	} item_t;

	typedef struct packed {
		logic [10:0] result_witness;
		logic        is_empty;
		logic        is_last;
	} result_t;

	// vertex set indexed by vertex number; bits 0, 6 and 7 stay clear
	function automatic logic [7:0] vertex_set(input logic [NUM_EDGES-1:0] e);
		logic [7:0] s;
		s = '0;
		for (int b = 0; b < NUM_EDGES; b++) begin
			if (e[b]) begin
				s[END_LOW[b]]  = 1'b1;
				s[END_HIGH[b]] = 1'b1;
			end
		end
		return s;
	endfunction

	function automatic logic [7:0] nbr_set(input logic [NUM_EDGES-1:0] e,
			input logic [2:0] v);
		logic [7:0] s;
		s = '0;
		for (int b = 0; b < NUM_EDGES; b++) begin
			if (e[b]) begin
				if (END_LOW[b] == v)
					s[END_HIGH[b]] = 1'b1;
				else if (END_HIGH[b] == v)
					s[END_LOW[b]] = 1'b1;
			end
		end
		return s;
	endfunction

	function automatic logic [NUM_EDGES-1:0] edge_mask(input logic [2:0] lo,
			input logic [2:0] hi);
		logic [NUM_EDGES-1:0] m;
		for (int b = 0; b < NUM_EDGES; b++)
			m[b] = (END_LOW[b] == lo) && (END_HIGH[b] == hi);
		return m;
	endfunction

	function automatic logic [3:0] popcount(input logic [NUM_EDGES-1:0] e);
		logic [3:0] c;
		c = '0;
		for (int b = 0; b < NUM_EDGES; b++)
			c = c + 4'(e[b]);
		return c;
	endfunction

	// k(k-1)/2
	function automatic logic [4:0] edge_target(input logic [2:0] k);
		logic [4:0] t;
		unique case (k)
			3'd0:    t = 5'd0;
			3'd1:    t = 5'd0;
			3'd2:    t = 5'd1;
			3'd3:    t = 5'd3;
			3'd4:    t = 5'd6;
			3'd5:    t = 5'd10;
			3'd6:    t = 5'd15;
			default: t = 5'd21;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/clique_witness_transition_core.sv =====
// Clique witness transition core: decode, count/decide and output stages.
// Depends on rtl/cwt_pkg.sv.
// Result path: stage 1 loads at the accepting edge, then stage 2, stage 3 and the
// output register, which strobes the first result; a second result follows in the
// cycle after it.
// Throughput: one transaction per cycle while busy is low; transactions with two results
// stall the pipeline; busy is high only during the cycle the second result is pending.
// Reset: arst_n clears valid bits, the pending flag and sets clique_size to 3.
`default_nettype none

module clique_witness_transition_core
	import cwt_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	output logic         busy,
	input  wire item_t   cmd,
	input  wire logic    cfg_we,
	input  wire logic [2:0] cfg_data,
	output logic         done,
	output result_t      result
);

	logic [2:0] k_q;

	// stage 1: registered transaction
	logic  vld_s1;
	item_t it_s1;

	// stage 2: decoded sets
	logic        vld_s2;
	logic [1:0]  act_s2;
	logic [10:0] wa_s2;
	logic [10:0] wb_s2;
	logic [9:0]  aug_s2;
	logic [9:0]  uni_s2;
	logic [7:0]  verts_a_s2;
	logic [7:0]  verts_aug_s2;
	logic [7:0]  verts_uni_s2;
	logic [7:0]  nbr_s2;
	logic        ok_s2;
	logic        both_in_s2;
	logic        va_in_s2;

	// stage 3: decided results
	logic        vld_s3;
	logic [10:0] r0_wit_s3;
	logic        r0_empty_s3;
	logic        two_s3;
	logic [10:0] r1_wit_s3;

	logic        pend_q;
	logic [10:0] pend_wit_q;

	logic advance;
	assign advance = !pend_q;
	assign busy    = pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= CLIQUE_SIZE_RESET;
		end else if (cfg_we) begin
			k_q <= cfg_data;
		end
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && start) begin
			it_s1 <= cmd;
		end
	end

	// stage 1 -> 2: set decode
	logic [2:0] lo_c;
	logic [2:0] hi_c;
	logic [9:0] aug_c;
	logic [9:0] uni_c;
	logic [7:0] verts_a_c;
	logic       ok_c;

	always_comb begin
		lo_c      = (it_s1.vertex_a < it_s1.vertex_b) ? it_s1.vertex_a : it_s1.vertex_b;
		hi_c      = (it_s1.vertex_a < it_s1.vertex_b) ? it_s1.vertex_b : it_s1.vertex_a;
		ok_c      = (it_s1.vertex_a >= 3'd1) && (it_s1.vertex_a <= 3'd5)
			&& (it_s1.vertex_b >= 3'd1) && (it_s1.vertex_b <= 3'd5)
			&& (it_s1.vertex_a != it_s1.vertex_b);
		aug_c     = it_s1.witness_a[10:1] | edge_mask(lo_c, hi_c);
		uni_c     = it_s1.witness_a[10:1] | it_s1.witness_b[10:1];
		verts_a_c = vertex_set(it_s1.witness_a[10:1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && vld_s1) begin
			act_s2       <= it_s1.action;
			wa_s2        <= it_s1.witness_a;
			wb_s2        <= it_s1.witness_b;
			aug_s2       <= aug_c;
			uni_s2       <= uni_c;
			verts_a_s2   <= verts_a_c;
			verts_aug_s2 <= vertex_set(aug_c);
			verts_uni_s2 <= vertex_set(uni_c);
			nbr_s2       <= nbr_set(it_s1.witness_a[10:1], it_s1.vertex_a);
			ok_s2        <= ok_c;
			both_in_s2   <= verts_a_c[it_s1.vertex_a] && verts_a_c[it_s1.vertex_b];
			va_in_s2     <= verts_a_c[it_s1.vertex_a];
		end
	end

	// stage 2 -> 3: counts and decision
	logic [3:0]  k_ext;
	logic [4:0]  target;
	logic [3:0]  nv_a;
	logic [3:0]  ne_aug;
	logic [3:0]  nv_aug;
	logic [3:0]  n_nbr;
	logic [3:0]  nv_uni;
	logic [3:0]  ne_uni;
	logic [10:0] r0_wit_c;
	logic        r0_empty_c;
	logic        two_c;

	always_comb begin
		k_ext      = {1'b0, k_q};
		target     = edge_target(k_q);
		nv_a       = popcount({2'b00, verts_a_s2});
		ne_aug     = popcount(aug_s2);
		nv_aug     = popcount({2'b00, verts_aug_s2});
		n_nbr      = popcount({2'b00, nbr_s2});
		nv_uni     = popcount({2'b00, verts_uni_s2});
		ne_uni     = popcount(uni_s2);
		r0_wit_c   = wa_s2;
		r0_empty_c = 1'b0;
		two_c      = 1'b0;
		unique case (act_s2)
			ACT_INTRO_VERTEX: begin
				r0_wit_c = wa_s2;
			end
			ACT_INTRO_EDGE: begin
				if (!wa_s2[0] && ok_s2) begin
					if (both_in_s2) begin
						if (nv_a == k_ext && {1'b0, ne_aug} == target)
							r0_wit_c = 11'd1;
						else
							r0_wit_c = {aug_s2, 1'b0};
					end else begin
						two_c = (nv_aug <= k_ext);
					end
				end
			end
			ACT_FORGET: begin
				if (!wa_s2[0] && va_in_s2 && (n_nbr + 4'd1) != k_ext) begin
					r0_wit_c   = '0;
					r0_empty_c = 1'b1;
				end
			end
			ACT_JOIN: begin
				if (wa_s2[0])
					r0_wit_c = wa_s2;
				else if (wb_s2[0])
					r0_wit_c = wb_s2;
				else if (nv_uni == k_ext && {1'b0, ne_uni} == target)
					r0_wit_c = 11'd1;
				else if (nv_uni <= k_ext && {1'b0, ne_uni} != target)
					r0_wit_c = {uni_s2, 1'b0};
				else begin
					r0_wit_c   = '0;
					r0_empty_c = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (advance) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && vld_s2) begin
			r0_wit_s3   <= r0_wit_c;
			r0_empty_s3 <= r0_empty_c;
			two_s3      <= two_c;
			r1_wit_s3   <= {aug_s2, 1'b0};
		end
	end

	// output register and second-result holding slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done   <= 1'b0;
			pend_q <= 1'b0;
		end else if (pend_q) begin
			done   <= 1'b1;
			pend_q <= 1'b0;
		end else begin
			done   <= vld_s3;
			pend_q <= vld_s3 && two_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q) begin
			result.result_witness <= pend_wit_q;
			result.is_empty       <= 1'b0;
			result.is_last        <= 1'b1;
		end else if (vld_s3) begin
			result.result_witness <= r0_wit_s3;
			result.is_empty       <= r0_empty_s3;
			result.is_last        <= !two_s3;
			pend_wit_q            <= r1_wit_s3;
		end
	end

	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held for more than one cycle");

	a_busy_after_first: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> done && !result.is_last)
		else $error("second result pending without a first result");

	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.is_last |=> done && result.is_last && !result.is_empty)
		else $error("second result of a transaction missing");

	a_empty_shape: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.is_empty |-> result.is_last && result.result_witness == 11'd0)
		else $error("empty result malformed");

endmodule

`default_nettype wire
